// ----- rtl/core/wfd_pkg.sv -----
// shared types and constants for the word frame deframer
`timescale 1ns / 1ps
package wfd_pkg;

  // assembled word travelling from the byte assembler to the frame parser
  typedef struct packed {
    logic        vld;
    logic [31:0] data;
  } wfd_word_t;

  typedef struct packed {
    logic [31:0] frame_name;
    logic [31:0] data_word;
    logic [15:0] word_index;
    logic        has_data;
    logic        last_of_frame;
  } wfd_result_t;

  typedef struct packed {
    logic [15:0] max_length;
    logic [15:0] handler_count;
  } wfd_cfg_t;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LENGTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HANDLER_COUNT = 8'd1;

  localparam logic [15:0] MAX_LENGTH_RST    = 16'd1000;
  localparam logic [15:0] HANDLER_COUNT_RST = 16'd16;

endpackage

// ----- rtl/core/wfd_assembler.sv -----
// gathers serial bytes into 32-bit little-endian words
`timescale 1ns / 1ps
module wfd_assembler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_in,
  output wfd_pkg::wfd_word_t word_o
);
  import wfd_pkg::*;

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] partial_r, partial_nxt;
  wfd_word_t   word_r, word_nxt;

  always_comb begin
    pos_nxt      = pos_r;
    partial_nxt  = partial_r;
    word_nxt.vld = 1'b0;
    word_nxt.data = {byte_in, partial_r};
    if (byte_vld) begin
      pos_nxt = pos_r + 2'd1;
      case (pos_r)
        2'd0: partial_nxt[7:0]   = byte_in;
        2'd1: partial_nxt[15:8]  = byte_in;
        2'd2: partial_nxt[23:16] = byte_in;
        default: begin
          // fourth byte completes the word
          word_nxt.vld = 1'b1;
          partial_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 2'd0;
      partial_r  <= '0;
      word_r.vld <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      partial_r  <= partial_nxt;
      word_r.vld <= word_nxt.vld;
    end
    word_r.data <= word_nxt.data;
  end

  assign word_o = word_r;

endmodule

// ----- rtl/core/wfd_parser.sv -----
// frame state machine: sync, name, length and data words
`timescale 1ns / 1ps
module wfd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wfd_pkg::wfd_word_t   word_i,
  input  wfd_pkg::wfd_cfg_t    cfg_i,
  output logic                 res_vld,
  output wfd_pkg::wfd_result_t res_o
);
  import wfd_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_NAME = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] name_r, name_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic        name_ok;
  logic        emit;

  assign name_ok = name_r < {16'd0, cfg_i.handler_count};

  always_comb begin
    phase_nxt  = phase_r;
    name_nxt   = name_r;
    remain_nxt = remain_r;
    idx_nxt    = idx_r;
    emit       = 1'b0;
    res_o.frame_name    = name_r;
    res_o.data_word     = word_i.data;
    res_o.word_index    = idx_r;
    res_o.has_data      = 1'b1;
    res_o.last_of_frame = (remain_r == 16'd1);
    if (word_i.vld) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (word_i.data == 32'd0) phase_nxt = PH_NAME;
        end
        PH_NAME: begin
          name_nxt  = word_i.data;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (word_i.data > {16'd0, cfg_i.max_length}) begin
            phase_nxt = PH_SYNC;
          end else if (word_i.data == 32'd0) begin
            // empty frame still gives one marker word
            emit                = 1'b1;
            res_o.data_word     = 32'd0;
            res_o.word_index    = 16'd0;
            res_o.has_data      = 1'b0;
            res_o.last_of_frame = 1'b1;
            phase_nxt           = PH_SYNC;
          end else begin
            remain_nxt = word_i.data[15:0];
            idx_nxt    = 16'd0;
            phase_nxt  = PH_DATA;
          end
        end
        PH_DATA: begin
          emit       = 1'b1;
          remain_nxt = remain_r - 16'd1;
          idx_nxt    = idx_r + 16'd1;
          if (remain_r == 16'd1) phase_nxt = PH_SYNC;
        end
        default: phase_nxt = PH_SYNC;
      endcase
    end
  end

  assign res_vld = emit && name_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC;
      name_r   <= '0;
      remain_r <= '0;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      name_r   <= name_nxt;
      remain_r <= remain_nxt;
      idx_r    <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // data phase is only entered with a nonzero count and left at the last word
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != 16'd0)
    else $error("data phase with zero words remaining");

  a_res_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> word_i.vld && (phase_r == PH_LEN || phase_r == PH_DATA))
    else $error("result without a completed word");
`endif

endmodule

// ----- rtl/core/wfd_out_fifo.sv -----
// two-entry result queue that decouples the parser from the output stream
`timescale 1ns / 1ps
module wfd_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wfd_pkg::wfd_result_t push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [1:0]           count,
  output wfd_pkg::wfd_result_t head
);
  import wfd_pkg::*;

  wfd_result_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_pop;

  assign do_pop = pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign not_empty = cnt_r != 2'd0;
  assign count     = cnt_r;
  assign head      = mem_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2))
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/word_frame_deframer.sv -----
// top level of the length-prefixed word deframer
`timescale 1ns / 1ps
// Takes one received byte per cycle on in_* and assembles 32-bit words, low
// byte first. A frame is a zero sync word, a name word, a length word and that
// many data words; nonzero words are skipped while waiting for sync, and a
// frame longer than max_length is dropped. For names below handler_count each
// data word comes out on out_* with its name and index, tlast on the final one,
// and a zero-length frame gives one word with tuser low. Throughput is one byte
// per cycle while in_tready is high; once its fourth byte is taken, a result
// passes through the byte assembler register, then the two-entry output queue.
// in_tready drops while the output queue holds two results, or holds one
// result while a completed word waits in the word stage. Registers: index 0
// max_length, index 1 handler_count; write them only while the block is idle.
// cfg_ready is always high.
module word_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] frame_name, [63:32] data_word, [79:64] word_index
  output logic [79:0]                    out_tdata,
  output logic                           out_tuser,  // [0] has_data
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import wfd_pkg::*;

  wfd_cfg_t    cfg_r, cfg_nxt;
  wfd_word_t   word;
  wfd_result_t res;
  wfd_result_t head;
  logic        res_vld;
  logic [1:0]  fifo_cnt;
  logic        in_acc;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_MAX_LENGTH:    cfg_nxt.max_length    = cfg_data;
        CFG_IDX_HANDLER_COUNT: cfg_nxt.handler_count = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length    <= MAX_LENGTH_RST;
      cfg_r.handler_count <= HANDLER_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // leave room for the word in flight and the one this byte may complete
  assign in_tready = (fifo_cnt == 2'd0) || (fifo_cnt == 2'd1 && !word.vld);
  assign in_acc    = in_tvalid && in_tready;

  wfd_assembler u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_vld(in_acc),
    .byte_in (in_tdata),
    .word_o  (word)
  );

  wfd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .word_i (word),
    .cfg_i  (cfg_r),
    .res_vld(res_vld),
    .res_o  (res)
  );

  wfd_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_data(res),
    .pop      (out_tready),
    .not_empty(out_tvalid),
    .count    (fifo_cnt),
    .head     (head)
  );

  assign out_tdata = {head.word_index, head.data_word, head.frame_name};
  assign out_tuser = head.has_data;
  assign out_tlast = head.last_of_frame;

endmodule
